// ===== hw/rtl/pma_pkg.sv =====
// pma_pkg: shared types and constants of the page map allocator
// holds the command struct passed from the front end to the back end, codes and state enums
// no dependencies
package pma_pkg;

   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;
   localparam int CNT_W      = 17;
   localparam int ADDR_W     = 32;
   localparam int BYTES_W    = 29;
   localparam int QUEUE_SLOTS = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_MAP_PAGES    = 2'd1;
   localparam logic [1:0] CSR_TAIL_PAGES   = 2'd2;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_RESERVE = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_FREE      = 3'd1,
      ST_MISALIGNED   = 3'd2,
      ST_SAME_STATE   = 3'd3,
      ST_OUT_OF_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      K_REPORT,
      K_ALLOC,
      K_SET,
      K_CLEAR,
      K_FREE_PAGE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [CNT_W-1:0]  first;
      logic [CNT_W-1:0]  last;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [CNT_W-1:0]  map_pages;
      logic [CNT_W-1:0]  tail_pages;
   } cfg_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_READ,
      BS_EVAL,
      BS_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      PH_ALLOC,
      PH_CHECK,
      PH_WRITE
   } phase_type;

endpackage

// ===== hw/rtl/pma_front.sv =====
// pma_front: accepts requests, range and alignment checks, turns them into commands
// depends on pma_pkg
module pma_front #(
   parameter int MAX_PAGES = 65536,
   parameter int PAGE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pma_pkg::cfg_type                cfg,
   input  logic                            clearing,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [pma_pkg::ADDR_W-1:0]      req_address,
   input  logic [pma_pkg::BYTES_W-1:0]     req_region_bytes,
   output logic                            q_push,
   output pma_pkg::cmd_type                q_cmd,
   input  logic                            q_full
);

   logic                            valid_ff, valid_in;
   pma_pkg::cmd_type                cmd_ff, cmd_in;
   pma_pkg::cmd_type                cls;
   logic [pma_pkg::CNT_W-1:0]       size;
   logic [pma_pkg::CNT_W-1:0]       limit;
   logic [pma_pkg::ADDR_W-1:0]      offset;
   logic [pma_pkg::ADDR_W-1:0]      idx;
   logic [pma_pkg::BYTES_W-1:0]     npages;
   logic [pma_pkg::ADDR_W:0]        end_idx;
   logic                            misaligned;
   logic                            accept;

   assign q_push    = valid_ff && !q_full;
   assign q_cmd     = cmd_ff;
   assign req_stall = clearing || (valid_ff && q_full);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (32'(cfg.map_pages) > MAX_PAGES) begin
         size = pma_pkg::CNT_W'(MAX_PAGES);
      end else begin
         size = cfg.map_pages;
      end
      limit      = (cfg.tail_pages >= size) ? '0 : size - cfg.tail_pages;
      offset     = req_address - cfg.base_address;
      idx        = offset >> PAGE_BITS;
      npages     = req_region_bytes >> PAGE_BITS;
      end_idx    = {1'b0, idx} + (pma_pkg::ADDR_W+1)'(npages);
      misaligned = ((req_address & ((32'd1 << PAGE_BITS) - 32'd1)) != '0) ||
                   ((32'(req_region_bytes) & ((32'd1 << PAGE_BITS) - 32'd1)) != '0);

      cls.kind   = pma_pkg::K_REPORT;
      cls.status = pma_pkg::ST_OK;
      cls.first  = idx[pma_pkg::CNT_W-1:0];
      cls.last   = end_idx[pma_pkg::CNT_W-1:0];
      cls.count  = npages[pma_pkg::CNT_W-1:0];
      case (pma_pkg::action_type'(req_action))
         pma_pkg::ACT_ALLOC: begin
            cls.first = '0;
            cls.last  = limit;
            cls.count = pma_pkg::CNT_W'(1);
            if (limit == '0) begin
               cls.status = pma_pkg::ST_NO_FREE;
            end else begin
               cls.kind = pma_pkg::K_ALLOC;
            end
         end
         pma_pkg::ACT_FREE: begin
            cls.last  = idx[pma_pkg::CNT_W-1:0] + pma_pkg::CNT_W'(1);
            cls.count = pma_pkg::CNT_W'(1);
            if (idx >= 32'(size)) begin
               cls.status = pma_pkg::ST_OUT_OF_RANGE;
            end else begin
               cls.kind = pma_pkg::K_FREE_PAGE;
            end
         end
         default: begin
            if (misaligned) begin
               cls.status = pma_pkg::ST_MISALIGNED;
            end else if (end_idx > 33'(size)) begin
               cls.status = pma_pkg::ST_OUT_OF_RANGE;
            end else if (npages == '0) begin
               cls.status = pma_pkg::ST_OK;
            end else if (req_action == pma_pkg::ACT_RESERVE) begin
               cls.kind = pma_pkg::K_SET;
            end else begin
               cls.kind = pma_pkg::K_CLEAR;
            end
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         cmd_in   = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== hw/rtl/pma_queue.sv =====
// pma_queue: short command queue between front end and back end
// depends on pma_pkg
module pma_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pma_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output pma_pkg::cmd_type head_cmd,
   output logic             empty
);

   localparam int PW = (pma_pkg::QUEUE_SLOTS > 1) ? $clog2(pma_pkg::QUEUE_SLOTS) : 1;
   localparam int FW = $clog2(pma_pkg::QUEUE_SLOTS + 1);

   pma_pkg::cmd_type slot_ff [pma_pkg::QUEUE_SLOTS];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;

   assign full     = (32'(fill_ff) == pma_pkg::QUEUE_SLOTS);
   assign empty    = (fill_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == pma_pkg::QUEUE_SLOTS - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == pma_pkg::QUEUE_SLOTS - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/pma_back.sv =====
// pma_back: executes commands against the page bitmap memory, keeps the used count
// and holds the response register; depends on pma_pkg
module pma_back #(
   parameter int MAX_PAGES = 65536,
   parameter int PAGE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pma_pkg::cfg_type               cfg,
   input  logic                           q_empty,
   input  pma_pkg::cmd_type               q_head,
   output logic                           q_pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic [pma_pkg::ADDR_W-1:0]     rsp_page_address,
   output logic [pma_pkg::CNT_W-1:0]      rsp_used_count
);

   localparam int W     = pma_pkg::WORD_BITS;
   localparam int WS    = pma_pkg::WORD_SHIFT;
   localparam int DEPTH = (MAX_PAGES + W - 1) / W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = pma_pkg::CNT_W;

   logic [W-1:0]                 mem [DEPTH];
   logic [W-1:0]                 rd_ff;

   pma_pkg::back_state_type      state_ff, state_in;
   pma_pkg::phase_type           phase_ff, phase_in;
   pma_pkg::cmd_type             cur_ff, cur_in;
   logic [AW-1:0]                word_ff, word_in;
   logic [CW-1:0]                count_ff, count_in;
   pma_pkg::status_type          res_status_ff, res_status_in;
   logic [pma_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic [pma_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;

   logic                         we;
   logic [W-1:0]                 wdata;
   logic [W-1:0]                 low_mask, high_mask, mask, cand, lowest;
   logic [WS-1:0]                bit_pos;
   logic                         is_last, clear_done, target, hit, slot_free;
   logic [AW-1:0]                first_word, head_word;
   logic [CW:0]                  sum_up;
   logic [CW-1:0]                cnt_up, cnt_down;

   assign clearing         = (state_ff == pma_pkg::BS_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_used_count   = rsp_count_ff;

   // shared conditions of the word sweep
   always_comb begin
      first_word = AW'(32'(cur_ff.first) >> WS);
      head_word  = AW'(32'(q_head.first) >> WS);
      is_last    = (32'(word_ff) == (32'(cur_ff.last - CW'(1)) >> WS));
      clear_done = (32'(word_ff) == DEPTH - 1);
      slot_free  = !rsp_valid_ff || !rsp_stall;
      target     = (cur_ff.kind == pma_pkg::K_SET);

      if (32'(word_ff) == (32'(cur_ff.first) >> WS)) begin
         low_mask = {W{1'b1}} << cur_ff.first[WS-1:0];
      end else begin
         low_mask = {W{1'b1}};
      end
      if (32'(word_ff) == (32'(cur_ff.last) >> WS)) begin
         high_mask = ~({W{1'b1}} << cur_ff.last[WS-1:0]);
      end else begin
         high_mask = {W{1'b1}};
      end
      mask   = low_mask & high_mask;
      cand   = ~rd_ff & mask;
      lowest = cand & (~cand + W'(1));
      hit    = target ? ((rd_ff & mask) != '0) : ((~rd_ff & mask) != '0);

      bit_pos = '0;
      for (int j = W - 1; j >= 0; j--) begin
         if (cand[j]) begin
            bit_pos = WS'(j);
         end
      end

      sum_up   = {1'b0, count_ff} + {1'b0, cur_ff.count};
      cnt_up   = sum_up[CW] ? pma_pkg::COUNT_MAX : sum_up[CW-1:0];
      cnt_down = (cur_ff.count >= count_ff) ? '0 : count_ff - cur_ff.count;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pma_pkg::BS_CLEAR: begin
            if (clear_done) begin
               state_in = pma_pkg::BS_IDLE;
            end
         end
         pma_pkg::BS_IDLE: begin
            if (!q_empty) begin
               state_in = (q_head.kind == pma_pkg::K_REPORT) ? pma_pkg::BS_DONE
                                                             : pma_pkg::BS_READ;
            end
         end
         pma_pkg::BS_READ: begin
            state_in = pma_pkg::BS_EVAL;
         end
         pma_pkg::BS_EVAL: begin
            case (phase_ff)
               pma_pkg::PH_ALLOC: begin
                  state_in = (cand != '0 || is_last) ? pma_pkg::BS_DONE : pma_pkg::BS_READ;
               end
               pma_pkg::PH_CHECK: begin
                  state_in = hit ? pma_pkg::BS_DONE : pma_pkg::BS_READ;
               end
               default: begin
                  state_in = is_last ? pma_pkg::BS_DONE : pma_pkg::BS_READ;
               end
            endcase
         end
         pma_pkg::BS_DONE: begin
            if (slot_free) begin
               state_in = pma_pkg::BS_IDLE;
            end
         end
         default: begin
            state_in = pma_pkg::BS_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      q_pop         = 1'b0;
      we            = 1'b0;
      wdata         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         pma_pkg::BS_CLEAR: begin
            we      = 1'b1;
            wdata   = '0;
            word_in = word_ff + AW'(1);
         end
         pma_pkg::BS_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               cur_in        = q_head;
               res_status_in = q_head.status;
               res_addr_in   = '0;
               word_in       = head_word;
               case (q_head.kind)
                  pma_pkg::K_ALLOC:     phase_in = pma_pkg::PH_ALLOC;
                  pma_pkg::K_FREE_PAGE: phase_in = pma_pkg::PH_WRITE;
                  default:              phase_in = pma_pkg::PH_CHECK;
               endcase
            end
         end
         pma_pkg::BS_EVAL: begin
            case (phase_ff)
               pma_pkg::PH_ALLOC: begin
                  if (cand != '0) begin
                     we            = 1'b1;
                     wdata         = rd_ff | lowest;
                     count_in      = cnt_up;
                     res_status_in = pma_pkg::ST_OK;
                     res_addr_in   = cfg.base_address +
                                     (32'({word_ff, bit_pos}) << PAGE_BITS);
                  end else if (is_last) begin
                     res_status_in = pma_pkg::ST_NO_FREE;
                  end else begin
                     word_in = word_ff + AW'(1);
                  end
               end
               pma_pkg::PH_CHECK: begin
                  if (hit) begin
                     res_status_in = pma_pkg::ST_SAME_STATE;
                  end else if (is_last) begin
                     phase_in = pma_pkg::PH_WRITE;
                     word_in  = first_word;
                  end else begin
                     word_in = word_ff + AW'(1);
                  end
               end
               default: begin
                  we    = 1'b1;
                  wdata = target ? (rd_ff | mask) : (rd_ff & ~mask);
                  if (is_last) begin
                     count_in      = target ? cnt_up : cnt_down;
                     res_status_in = pma_pkg::ST_OK;
                  end else begin
                     word_in = word_ff + AW'(1);
                  end
               end
            endcase
         end
         pma_pkg::BS_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pma_pkg::BS_CLEAR;
         word_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // bitmap memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[word_ff] <= wdata;
      end
      rd_ff <= mem[word_ff];
   end

endmodule

// ===== hw/rtl/page_map_allocator_core.sv =====
// page_map_allocator_core: bitmap first-fit physical page allocator, top level
// depends on pma_pkg, pma_front, pma_queue, pma_back
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    action, address, region_bytes
//  rsp      out        rsp_valid/stall    status, page_address, used_count
//  csr      in         csr_valid/ready    index, data
//
// the bitmap is read and written one 64-page word at a time by the back end, in a READ then an EVAL state
// allocate: scans words from the first one up to the first free page and marks that page used
// region ops: check sweep then write sweep over the words of the region; rejected requests skip both sweeps
// after reset a clearing pass zeroes every bitmap word and runs with req_stall high
// a finished response waits in the output register while the next request proceeds
module page_map_allocator_core #(
   parameter int MAX_PAGES = 65536,
   parameter int PAGE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [pma_pkg::ADDR_W-1:0]     req_address,
   input  logic [pma_pkg::BYTES_W-1:0]    req_region_bytes,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic [pma_pkg::ADDR_W-1:0]     rsp_page_address,
   output logic [pma_pkg::CNT_W-1:0]      rsp_used_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [31:0]                    csr_data
);

   pma_pkg::cfg_type  cfg_ff, cfg_in;
   pma_pkg::cmd_type  push_cmd, head_cmd;
   logic              q_push, q_full, q_pop, q_empty, clearing;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pma_pkg::CSR_BASE_ADDRESS: cfg_in.base_address = csr_data;
            pma_pkg::CSR_MAP_PAGES:    cfg_in.map_pages    = csr_data[pma_pkg::CNT_W-1:0];
            pma_pkg::CSR_TAIL_PAGES:   cfg_in.tail_pages   = csr_data[pma_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pma_front #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BITS (PAGE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .clearing         (clearing),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_region_bytes (req_region_bytes),
      .q_push           (q_push),
      .q_cmd            (push_cmd),
      .q_full           (q_full)
   );

   pma_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   pma_back #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BITS (PAGE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_head           (head_cmd),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_used_count   (rsp_used_count)
   );

endmodule

// ===== hw/rtl/pma_checker.sv =====
// pma_checker: port-level assertions for page_map_allocator_core, with its bind
// depends on pma_pkg
module pma_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [2:0]                     rsp_status,
   input logic [pma_pkg::ADDR_W-1:0]     rsp_page_address,
   input logic [pma_pkg::CNT_W-1:0]      rsp_used_count
);

   // no response comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // only a successful allocate carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != pma_pkg::ST_OK) |-> (rsp_page_address == '0))
      else $error("failed action returned a page address");

   // the map is being cleared right after reset, so no request is taken
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_page_address) && $stable(rsp_used_count)))
      else $error("stalled response changed");

endmodule

bind page_map_allocator_core pma_checker u_pma_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_page_address (rsp_page_address),
   .rsp_used_count   (rsp_used_count)
);
